FILE: hw/rtl/bbrm_pkg.sv
// shared types and codes of the two-region buffer manager
package bbrm_pkg;

    localparam int FIELD_W  = 13;
    localparam int ACTION_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_QUERY  = 2'd0,
        ACT_COMMIT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    // one result; the last member sits in the lowest bits
    typedef struct packed {
        logic               overflow;
        logic [FIELD_W-1:0] move_count;
        logic [FIELD_W-1:0] move_source;
        logic               move_request;
        logic               second_open;
        logic [FIELD_W-1:0] second_count;
        logic [FIELD_W-1:0] primary_count;
        logic [FIELD_W-1:0] read_offset;
        logic [FIELD_W-1:0] write_offset;
        logic [FIELD_W-1:0] free_space;
    } t_result;

endpackage

FILE: hw/rtl/bbrm_ctrl.sv
// controller: request intake, execute step and output register handshake
module bbrm_ctrl
    import bbrm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   can_exec;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign can_exec    = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load = i_in_valid && (r_state == S_IDLE);
        o_cmd.exec = (r_state == S_EXEC) && can_exec;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_EXEC;
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (o_cmd.exec) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/bbrm_datapath.sv
// datapath: region registers, step arithmetic and result register
module bbrm_datapath
    import bbrm_pkg::*;
#(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [FIELD_W-1:0] i_length,
    output t_result            o_result
);

    localparam int W  = $clog2(BUFFER_BYTES + 1);
    localparam int CW = (W > FIELD_W) ? W : FIELD_W;
    localparam logic [CW-1:0] BUF_C = CW'(BUFFER_BYTES);

    logic [ACTION_W-1:0] r_action;
    logic [FIELD_W-1:0]  r_length;

    logic [W-1:0] r_p_start, r_p_len, r_s_start, r_s_len;
    logic         r_s_act;
    logic [W-1:0] n_p_start, n_p_len, n_s_start, n_s_len;
    logic         n_s_act;

    t_result r_res, n_res;

    logic [CW-1:0] ps, pl, ss, sl, len;
    logic [CW-1:0] p_end, s_end, after, free_s, room, amt;
    logic [CW-1:0] take_p, rest, take_s, pl2, ps2, sl2, ss2;
    logic [CW-1:0] free_v, mv_src, mv_cnt, wr;
    logic          mv_req, ovf;

    always_comb begin
        ps     = CW'(r_p_start);
        pl     = CW'(r_p_len);
        ss     = CW'(r_s_start);
        sl     = CW'(r_s_len);
        len    = CW'(r_length);
        p_end  = ps + pl;
        s_end  = ss + sl;
        after  = (BUF_C > p_end) ? (BUF_C - p_end) : '0;
        free_s = (ps > s_end) ? (ps - s_end) : '0;
        room   = r_s_act ? free_s : after;
        amt    = (len > room) ? room : len;
        // remove: primary first, then the rest from the second region
        take_p = (len > pl) ? pl : len;
        rest   = len - take_p;
        take_s = (rest > sl) ? sl : rest;
        pl2    = pl - take_p;
        ps2    = ps + take_p;
        sl2    = sl - take_s;
        ss2    = ss + take_s;
    end

    always_comb begin
        n_p_start = r_p_start;
        n_p_len   = r_p_len;
        n_s_start = r_s_start;
        n_s_len   = r_s_len;
        n_s_act   = r_s_act;
        free_v    = '0;
        mv_req    = 1'b0;
        mv_src    = '0;
        mv_cnt    = '0;
        ovf       = 1'b0;
        unique case (t_action'(r_action))
            ACT_QUERY: begin
                if (!r_s_act && (ps > after)) begin
                    n_s_act   = 1'b1;
                    n_s_start = '0;
                    n_s_len   = '0;
                    free_v    = ps;
                end else begin
                    free_v = room;
                end
            end
            ACT_COMMIT: begin
                ovf = (len > room);
                if (r_s_act) begin
                    n_s_len = W'(sl + amt);
                end else begin
                    n_p_len = W'(pl + amt);
                end
            end
            ACT_REMOVE: begin
                if (pl2 == '0) begin
                    // primary emptied: second region moves down to offset zero
                    if ((sl2 != '0) && (ss2 != '0)) begin
                        mv_req = 1'b1;
                        mv_src = ss2;
                        mv_cnt = sl2;
                    end
                    n_p_len   = W'(sl2);
                    n_p_start = '0;
                    n_s_act   = 1'b0;
                    n_s_start = '0;
                    n_s_len   = '0;
                end else begin
                    n_p_len   = W'(pl2);
                    n_p_start = W'(ps2);
                    n_s_len   = W'(sl2);
                    n_s_start = W'(ss2);
                end
            end
            ACT_NONE: begin
            end
            default: begin
            end
        endcase
        wr = n_s_act ? (CW'(n_s_start) + CW'(n_s_len)) : (CW'(n_p_start) + CW'(n_p_len));
    end

    always_comb begin
        n_res.free_space    = free_v[FIELD_W-1:0];
        n_res.write_offset  = wr[FIELD_W-1:0];
        n_res.primary_count = FIELD_W'(CW'(n_p_len));
        n_res.second_count  = FIELD_W'(CW'(n_s_len));
        n_res.second_open   = n_s_act;
        n_res.move_request  = mv_req;
        n_res.move_source   = mv_src[FIELD_W-1:0];
        n_res.move_count    = mv_cnt[FIELD_W-1:0];
        n_res.overflow      = ovf;
        n_res.read_offset   = FIELD_W'(CW'(n_p_start));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_start <= '0;
            r_p_len   <= '0;
            r_s_start <= '0;
            r_s_len   <= '0;
            r_s_act   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_p_start <= n_p_start;
            r_p_len   <= n_p_len;
            r_s_start <= n_s_start;
            r_s_len   <= n_s_len;
            r_s_act   <= n_s_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_length <= i_length;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

FILE: hw/rtl/bipartite_buffer_region_manager_top.sv
// top level of the two-region buffer manager
//
// channel   dir  tdata                  tuser
// s_axis    in   length[12:0]           action[1:0]
// m_axis    out  result fields, 96 bit  -
//
// a request is first registered, then the execute step runs it and loads the
// output register; a new request is taken while a result waits
// a request whose result cannot be loaded waits in the execute step until
// m_axis_tready frees the output register
// reset clears all offsets and lengths to zero and closes the second region
module bipartite_buffer_region_manager_top
    import bbrm_pkg::*;
#(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // length[12:0], zero[15:13]
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // free_space[12:0], write_offset[25:13], read_offset[38:26],
    // primary_count[51:39], second_count[64:52], second_open[65],
    // move_request[66], move_source[79:67], move_count[92:80],
    // overflow[93], zero[95:94]
    output logic [95:0] m_axis_tdata
);

    t_dp_cmd cmd;
    t_result result;

    bbrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    bbrm_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_action (s_axis_tuser),
        .i_length (s_axis_tdata[FIELD_W-1:0]),
        .o_result (result)
    );

    assign m_axis_tdata = {2'b00, result};

`ifndef NO_ASSERTIONS
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while previous one still executing");

    a_exec_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> m_axis_tvalid)
        else $error("executed step did not present a result");

    a_stall_holds_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && !s_axis_tready) |=> !s_axis_tready)
        else $error("pending request dropped while output stalled");

    a_exec_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before it was taken");
`endif

endmodule
